// ===== rtl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types, constants and command codes for the ordered array store.
// ----------------------------------------------------------------------------
package oas_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [3:0] OP_PUSH   = 4'd0;
    localparam logic [3:0] OP_POP    = 4'd1;
    localparam logic [3:0] OP_INSERT = 4'd2;
    localparam logic [3:0] OP_ERASE  = 4'd3;
    localparam logic [3:0] OP_REMOVE = 4'd4;
    localparam logic [3:0] OP_FIND   = 4'd5;
    localparam logic [3:0] OP_READ   = 4'd6;
    localparam logic [3:0] OP_WRITE  = 4'd7;
    localparam logic [3:0] OP_CLEAR  = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADIDX   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0]            opcode;
        logic [6:0]            position;
        logic [DATA_WIDTH-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_out;
        logic [5:0]            found_position;
        logic [2:0]            status;
        logic [6:0]            removed_count;
        logic [6:0]            entry_count;
        logic                  is_empty;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic            rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic            wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic            wr_sel_val;   // write the command value, else read data
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rd_data;
        logic                  rd_match;
    } dp_stat_t;

endpackage

// ===== rtl/oas_datapath.sv =====
// ----------------------------------------------------------------------------
// oas_datapath
// Entry memory with one write port and one registered read port, plus the
// value compare used by find and remove.
// ----------------------------------------------------------------------------
module oas_datapath
(
    input  logic                          clk,
    input  oas_pkg::dp_cmd_t              cmd,
    input  logic [oas_pkg::DATA_WIDTH-1:0] value,
    output oas_pkg::dp_stat_t             stat
);
    import oas_pkg::*;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_sel_val ? value : rd_data_reg;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign stat.rd_data  = rd_data_reg;
    assign stat.rd_match = (rd_data_reg == value);

endmodule

// ===== rtl/oas_ctrl.sv =====
// ----------------------------------------------------------------------------
// oas_ctrl
// Command sequencer: holds the entry count, walks the memory for shifts,
// compaction and search, and builds the result word.
// ----------------------------------------------------------------------------
module oas_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  oas_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output oas_pkg::out_word_t  out_word,
    output oas_pkg::dp_cmd_t    cmd,
    input  oas_pkg::dp_stat_t   stat,
    output logic [oas_pkg::DATA_WIDTH-1:0] cmd_value
);
    import oas_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POPRD = 3'd1;  // read issued, data next cycle
    localparam logic [2:0] S_INS   = 3'd2;  // shift up, top down
    localparam logic [2:0] S_ERA   = 3'd3;  // shift down
    localparam logic [2:0] S_REM   = 3'd4;  // compact
    localparam logic [2:0] S_FIND  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_INSWR = 3'd7;  // final insert write

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;     // walk index
    logic [CNT_W-1:0] keep_reg, keep_next;   // compaction write index
    logic [CNT_W-1:0] pend_reg, pend_next;   // index whose read data is pending
    logic             rdv_reg, rdv_next;     // read data valid
    in_word_t         cur_reg, cur_next;
    out_word_t        res_reg, res_next;
    logic             ov_reg, ov_next;

    logic accept;
    logic out_free;

    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_word  = res_reg;
    // Idle-state writes (push, write) take the value straight from the input word
    assign cmd_value = (state_reg == S_IDLE) ? in_word.value : cur_reg.value;

    function automatic out_word_t mk_res(logic [DATA_WIDTH-1:0] d, logic [5:0] f,
                                         logic [2:0] s, logic [6:0] r,
                                         logic [CNT_W-1:0] c);
        out_word_t o;
        o.data_out       = d;
        o.found_position = f;
        o.status         = s;
        o.removed_count  = r;
        o.entry_count    = 7'(c);
        o.is_empty       = (c == '0);
        return o;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        keep_next  = keep_reg;
        pend_next  = pend_reg;
        rdv_next   = 1'b0;
        cur_next   = cur_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = in_word;
                    state_next = S_DONE;
                    case (in_word.opcode)
                        OP_PUSH:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_next = mk_res('0, '0, ST_FULL, '0, count_reg);
                            end
                            else
                            begin
                                cmd.wr_en = 1'b1;
                                cmd.wr_sel_val = 1'b1;
                                cmd.wr_addr = ADDR_W'(count_reg);
                                count_next = count_reg + 1'b1;
                                res_next = mk_res('0, '0, ST_OK, '0, count_next);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = mk_res('0, '0, ST_EMPTY, '0, count_reg);
                            end
                            else
                            begin
                                cmd.rd_en = 1'b1;
                                cmd.rd_addr = ADDR_W'(count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                state_next = S_POPRD;
                            end
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(in_word.position) >= count_reg ||
                                in_word.position > 7'(CAPACITY))
                            begin
                                res_next = mk_res('0, '0, ST_BADIDX, '0, count_reg);
                            end
                            else
                            begin
                                cmd.rd_en = 1'b1;
                                cmd.rd_addr = ADDR_W'(in_word.position);
                                state_next = S_POPRD;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (CNT_W'(in_word.position) >= count_reg)
                            begin
                                res_next = mk_res('0, '0, ST_BADIDX, '0, count_reg);
                            end
                            else
                            begin
                                cmd.wr_en = 1'b1;
                                cmd.wr_sel_val = 1'b1;
                                cmd.wr_addr = ADDR_W'(in_word.position);
                                res_next = mk_res('0, '0, ST_OK, '0, count_reg);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_next = mk_res('0, '0, ST_FULL, '0, count_reg);
                            end
                            else if (CNT_W'(in_word.position) > count_reg)
                            begin
                                res_next = mk_res('0, '0, ST_BADIDX, '0, count_reg);
                            end
                            else
                            begin
                                idx_next = count_reg;
                                state_next = S_INS;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next = mk_res('0, '0, ST_EMPTY, '0, count_reg);
                            end
                            else if (CNT_W'(in_word.position) >= count_reg)
                            begin
                                res_next = mk_res('0, '0, ST_BADIDX, '0, count_reg);
                            end
                            else
                            begin
                                idx_next = CNT_W'(in_word.position);
                                state_next = S_ERA;
                            end
                        end
                        OP_REMOVE:
                        begin
                            idx_next = '0;
                            keep_next = '0;
                            state_next = S_REM;
                        end
                        OP_FIND:
                        begin
                            idx_next = '0;
                            state_next = S_FIND;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            res_next = mk_res('0, '0, ST_OK, '0, '0);
                        end
                        default:
                        begin
                            res_next = mk_res('0, '0, ST_OK, '0, count_reg);
                        end
                    endcase
                end
            end

            S_POPRD:
            begin
                res_next = mk_res(stat.rd_data, '0, ST_OK, '0, count_reg);
                state_next = S_DONE;
            end

            // Shift up: read idx-1, next cycle write it at idx
            S_INS:
            begin
                if (rdv_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = ADDR_W'(pend_reg + 1'b1);
                end
                if (idx_reg > CNT_W'(cur_reg.position))
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = ADDR_W'(idx_reg - 1'b1);
                    pend_next = idx_reg - 1'b1;
                    rdv_next = 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
                else if (!rdv_reg)
                begin
                    state_next = S_INSWR;
                end
            end

            S_INSWR:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel_val = 1'b1;
                cmd.wr_addr = ADDR_W'(cur_reg.position);
                count_next = count_reg + 1'b1;
                res_next = mk_res('0, '0, ST_OK, '0, count_next);
                state_next = S_DONE;
            end

            // Shift down: read idx+1, next cycle write it at idx
            S_ERA:
            begin
                if (rdv_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = ADDR_W'(pend_reg - 1'b1);
                end
                if (idx_reg + 1'b1 < count_reg)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = ADDR_W'(idx_reg + 1'b1);
                    pend_next = idx_reg + 1'b1;
                    rdv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    count_next = count_reg - 1'b1;
                    res_next = mk_res('0, '0, ST_OK, '0, count_next);
                    state_next = S_DONE;
                end
            end

            // Compact: keep non-matching entries
            S_REM:
            begin
                if (rdv_reg)
                begin
                    if (!stat.rd_match)
                    begin
                        cmd.wr_en = 1'b1;
                        cmd.wr_addr = ADDR_W'(keep_reg);
                        keep_next = keep_reg + 1'b1;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = ADDR_W'(idx_reg);
                    rdv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    count_next = keep_reg;
                    res_next = mk_res('0, '0, ST_OK, 7'(count_reg - keep_reg), keep_reg);
                    state_next = S_DONE;
                end
            end

            S_FIND:
            begin
                if (rdv_reg && stat.rd_match)
                begin
                    res_next = mk_res('0, 6'(pend_reg), ST_OK, '0, count_reg);
                    state_next = S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = ADDR_W'(idx_reg);
                    pend_next = idx_reg;
                    rdv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rdv_reg || !stat.rd_match)
                begin
                    if (!rdv_reg)
                    begin
                        res_next = mk_res('0, '0, ST_NOTFOUND, '0, count_reg);
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        keep_reg <= keep_next;
        pend_reg <= pend_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

endmodule

// ===== rtl/ordered_array_store.sv =====
// ----------------------------------------------------------------------------
// ordered_array_store
// Fixed-capacity ordered array driven by one command word per item.
// ----------------------------------------------------------------------------
// Usage: a command word (opcode, position, value) enters on in_valid/in_stall
// and exactly one result word leaves on out_valid/out_stall.
// One command is worked on at a time; in_stall stays high while a command is
// in flight or while an earlier result still waits at the output register.
// Push, write, clear, error cases and undefined opcodes pass from idle
// through the done state; pop and read also pass the pop read state.
// Insert, erase, remove and find walk the entry memory, with its one
// write port and one registered read port, one entry per cycle.
// Reset clears the entry count and the control state; the entry memory is
// not cleared, only entries below the count are ever read.
// When the receiver stalls, the result word holds steady and no new
// command is taken until it is gone.
// ----------------------------------------------------------------------------
module ordered_array_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  oas_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output oas_pkg::out_word_t out_word
);
    import oas_pkg::*;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [DATA_WIDTH-1:0] cmd_value;

    oas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (cmd),
        .stat      (stat),
        .cmd_value (cmd_value)
    );

    oas_datapath u_dp
    (
        .clk   (clk),
        .cmd   (cmd),
        .value (cmd_value),
        .stat  (stat)
    );

    // Count never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.entry_count <= 7'(CAPACITY))
        else $error("entry count above capacity");

    // Empty flag agrees with the count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.is_empty == (out_word.entry_count == 7'd0)))
        else $error("empty flag mismatch");

    // No command taken while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken with result pending");

endmodule
